>>> rtl/hsac_pkg.sv
package hsac_pkg;

  localparam int INDEX_BITS   = 9;
  localparam int WAYS         = 16;
  localparam int PAYLOAD_BITS = 64;

  localparam int KEY_BITS     = 32;
  localparam int STATUS_BITS  = 3;
  localparam int PAYLOAD_PORT = 64;
  localparam int BUCKETS      = 1 << INDEX_BITS;
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_BITS     = WAYS * KEY_BITS;
  localparam int PAY_AW       = INDEX_BITS + WAY_W;
  localparam int PAY_DEPTH    = 1 << PAY_AW;
  localparam int HASH_SHIFT   = 16;

  localparam logic [KEY_BITS-1:0] HASH_MUL     = 32'h9E37_79B1;
  localparam logic [KEY_BITS-1:0] TAG_FREE     = 32'h0000_0000;
  localparam logic [KEY_BITS-1:0] KEY_RESERVED = 32'h0000_0001;

  localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_RESERVED = 3'd5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;   // clear one tag row
    logic capture;  // take the input beat
    logic tag_rd;   // read the bucket row
    logic finish;   // commit insert and load a non-hit result
    logic pay_rd;   // read the payload of the hit way
    logic pay_load; // load the hit result
  } hsac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_pay;
    logic out_free;
  } hsac_sts_t;

  function automatic logic [INDEX_BITS-1:0] hsac_hash(input logic [KEY_BITS-1:0] key);
    logic [KEY_BITS-1:0] h;
    logic [KEY_BITS-1:0] m;
    h = key ^ (key >> HASH_SHIFT);
    m = h * HASH_MUL;
    return m[KEY_BITS-1 -: INDEX_BITS];
  endfunction

endpackage

>>> rtl/hsac_ram.sv
module hsac_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/hsac_ctrl.sv
module hsac_ctrl
  import hsac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hsac_sts_t sts_i,
  output hsac_cmd_t cmd_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_PAY  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.tag_rd = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        // hold the compare until the output slot can take the result
        if (sts_i.out_free) begin
          if (sts_i.need_pay) begin
            cmd_o.pay_rd = 1'b1;
            state_d      = S_PAY;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_PAY: begin
        if (sts_i.out_free) begin
          cmd_o.pay_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/hsac_dp.sv
module hsac_dp
  import hsac_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsac_cmd_t               cmd_i,
  output hsac_sts_t               sts_o,
  input  logic                    cmd_in_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_PORT-1:0] payload_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STATUS_BITS-1:0]  status_o,
  output logic [PAYLOAD_PORT-1:0] payload_out_o
);

  logic                    op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [INDEX_BITS-1:0]   bucket_q;
  logic [INDEX_BITS-1:0]   clr_cnt_q;

  logic                    out_valid_q;
  logic [STATUS_BITS-1:0]  status_q;
  logic [PAYLOAD_PORT-1:0] payload_out_q;

  logic [ROW_BITS-1:0]     row;
  logic [ROW_BITS-1:0]     new_row;
  logic [WAYS-1:0]         match;
  logic [WAYS-1:0]         empty;
  logic [WAY_W-1:0]        match_idx;
  logic [WAY_W-1:0]        empty_idx;
  logic                    hit;
  logic                    has_empty;
  logic                    reserved;
  logic                    do_insert;
  logic [STATUS_BITS-1:0]  status_d;
  logic [PAYLOAD_BITS-1:0] pay_rd_data;

  logic                    tag_wr_en;
  logic [INDEX_BITS-1:0]   tag_wr_addr;
  logic [ROW_BITS-1:0]     tag_wr_data;

  // input beat, bucket hashed straight off the port
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= cmd_in_i;
      key_q    <= key_i;
      pay_q    <= payload_in_i[PAYLOAD_BITS-1:0];
      bucket_q <= hsac_hash(key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // compare all ways of the bucket row
  always_comb begin
    match_idx = '0;
    empty_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (row[w*KEY_BITS +: KEY_BITS] == key_q);
      empty[w] = (row[w*KEY_BITS +: KEY_BITS] == TAG_FREE);
    end
    // lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) match_idx = WAY_W'(w);
      if (empty[w]) empty_idx = WAY_W'(w);
    end
    new_row = row;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == empty_idx) new_row[w*KEY_BITS +: KEY_BITS] = key_q;
    end
  end

  assign hit       = |match;
  assign has_empty = |empty;
  assign reserved  = (key_q == TAG_FREE) || (key_q == KEY_RESERVED);
  assign do_insert = cmd_i.finish && (op_q == CMD_INSERT) && !reserved && !hit && has_empty;

  always_comb begin
    if (reserved) begin
      status_d = ST_RESERVED;
    end else if (op_q == CMD_LOOKUP) begin
      status_d = hit ? ST_HIT : ST_MISS;
    end else if (hit) begin
      status_d = ST_PRESENT;
    end else if (!has_empty) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  assign tag_wr_en   = cmd_i.clr_wr || do_insert;
  assign tag_wr_addr = cmd_i.clr_wr ? clr_cnt_q : bucket_q;
  assign tag_wr_data = cmd_i.clr_wr ? '0 : new_row;

  hsac_ram #(
    .Width(ROW_BITS),
    .Depth(BUCKETS)
  ) u_tag_ram (
    .clk_i    (clk_i),
    .wr_en_i  (tag_wr_en),
    .wr_addr_i(tag_wr_addr),
    .wr_data_i(tag_wr_data),
    .rd_en_i  (cmd_i.tag_rd),
    .rd_addr_i(bucket_q),
    .rd_data_o(row)
  );

  hsac_ram #(
    .Width(PAYLOAD_BITS),
    .Depth(PAY_DEPTH)
  ) u_pay_ram (
    .clk_i    (clk_i),
    .wr_en_i  (do_insert),
    .wr_addr_i({bucket_q, empty_idx}),
    .wr_data_i(pay_q),
    .rd_en_i  (cmd_i.pay_rd),
    .rd_addr_i({bucket_q, match_idx}),
    .rd_data_o(pay_rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish || cmd_i.pay_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q      <= status_d;
      payload_out_q <= '0;
    end else if (cmd_i.pay_load) begin
      status_q      <= ST_HIT;
      payload_out_q <= PAYLOAD_PORT'(pay_rd_data);
    end
  end

  assign sts_o.clr_last = &clr_cnt_q;
  assign sts_o.need_pay = !reserved && (op_q == CMD_LOOKUP) && hit;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign payload_out_o = payload_out_q;

endmodule

>>> rtl/hashed_set_assoc_decode_cache.sv
// Hashed set-associative decode cache: each beat is a lookup or an insert of a
// 32-bit key and returns exactly one result beat with a status and, on a hit,
// the stored payload. The bucket is the top index bits of
// (key ^ key>>16) * 0x9E3779B1; every bucket row of tags is read in one access
// of the tag RAM and all ways are compared at once. One beat is in flight at a
// time: a lookup miss or any insert passes through accept, tag row read, and
// compare and commit before the next accept; a hit also reads the payload RAM
// after the hit way is known. A stalled output holds the compare until the
// result register frees up. After reset the tag RAM is cleared one row per
// cycle, all 512 rows, with in_ready_o low.
module hashed_set_assoc_decode_cache
  import hsac_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_PORT-1:0] payload_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STATUS_BITS-1:0]  status_o,
  output logic [PAYLOAD_PORT-1:0] payload_out_o
);

  hsac_cmd_t ctrl_cmd;
  hsac_sts_t dp_sts;

  hsac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (dp_sts),
    .cmd_o     (ctrl_cmd)
  );

  hsac_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .sts_o        (dp_sts),
    .cmd_in_i     (cmd_i),
    .key_i        (key_i),
    .payload_in_i (payload_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .payload_out_o(payload_out_o)
  );

endmodule

>>> rtl/hsac_checker.sv
module hsac_checker
  import hsac_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [STATUS_BITS-1:0]  status_o,
  input logic [PAYLOAD_PORT-1:0] payload_out_o
);

  // a result beat waits, unchanged, until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(payload_out_o))
    else $error("result beat dropped or changed while stalled");

  // only a hit carries a payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_HIT) |-> (payload_out_o == '0))
    else $error("non-hit result with nonzero payload");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_RESERVED))
    else $error("status code out of range");

  // one beat in flight: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

endmodule

bind hashed_set_assoc_decode_cache hsac_checker u_hsac_checker (.*);

>>> tb/tb_hashed_set_assoc_decode_cache.sv
module tb_hashed_set_assoc_decode_cache
  import hsac_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1525;
  localparam int HOT_SETS     = 6;
  localparam int HOT_PER_SET  = 20;
  localparam int LONG_HOLD    = 150;
  localparam logic [PAYLOAD_PORT-1:0] PAY_MASK =
    {PAYLOAD_PORT{1'b1}} >> (PAYLOAD_PORT - PAYLOAD_BITS);

  typedef struct {
    logic [STATUS_BITS-1:0]  status;
    logic [PAYLOAD_PORT-1:0] payload;
  } cache_reply_t;

  class cache_checker;
    logic [KEY_BITS-1:0]     tags [BUCKETS*WAYS];
    logic [PAYLOAD_PORT-1:0] data [BUCKETS*WAYS];
    cache_reply_t            awaited_q [$];
    int unsigned             errors;

    function new();
      foreach (tags[i]) begin
        tags[i] = TAG_FREE;
        data[i] = '0;
      end
      errors = 0;
    endfunction

    function int unsigned set_index(logic [KEY_BITS-1:0] key);
      logic [KEY_BITS-1:0] folded;
      logic [KEY_BITS-1:0] prod;
      folded = key ^ (key >> HASH_SHIFT);
      prod   = folded * HASH_MUL;
      return prod >> (KEY_BITS - INDEX_BITS);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // work out the reply of one accepted request and update the tag copy
    function void note_request(logic cmd, logic [KEY_BITS-1:0] key,
                               logic [PAYLOAD_PORT-1:0] pay);
      cache_reply_t r;
      int unsigned  base;
      int           hit_way;
      int           free_way;
      r.status  = ST_MISS;
      r.payload = '0;
      hit_way   = -1;
      free_way  = -1;
      if (key == TAG_FREE || key == KEY_RESERVED) begin
        r.status = ST_RESERVED;
      end else begin
        base = set_index(key) * WAYS;
        for (int w = 0; w < WAYS; w++) begin
          if (hit_way < 0 && tags[base+w] == key) hit_way = w;
          if (free_way < 0 && tags[base+w] == TAG_FREE) free_way = w;
        end
        if (cmd == CMD_LOOKUP) begin
          if (hit_way >= 0) begin
            r.status  = ST_HIT;
            r.payload = data[base+hit_way] & PAY_MASK;
          end
        end else if (hit_way >= 0) begin
          r.status = ST_PRESENT;
        end else if (free_way < 0) begin
          r.status = ST_FULL;
        end else begin
          tags[base+free_way] = key;
          data[base+free_way] = pay & PAY_MASK;
          r.status = ST_INSERTED;
        end
      end
      awaited_q.push_back(r);
    endfunction

    task check_reply(logic [STATUS_BITS-1:0] status, logic [PAYLOAD_PORT-1:0] pay);
      cache_reply_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("reply status %0d with no request outstanding", status));
        return;
      end
      want = awaited_q.pop_front();
      if (status !== want.status)
        report($sformatf("status got %0d want %0d", status, want.status));
      if (pay !== want.payload)
        report($sformatf("payload got %h want %h", pay, want.payload));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    cmd_i;
  logic [KEY_BITS-1:0]     key_i;
  logic [PAYLOAD_PORT-1:0] payload_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [STATUS_BITS-1:0]  status_o;
  logic [PAYLOAD_PORT-1:0] payload_out_o;

  cache_checker sb = new();
  bit calm;
  bit long_hold;

  hashed_set_assoc_decode_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .payload_in_i  (payload_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .payload_out_o (payload_out_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("tb_hashed_set_assoc_decode_cache NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(cmd_i, key_i, payload_in_i);
      if (out_valid_o && out_ready_i) sb.check_reply(status_o, payload_out_o);
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [PAYLOAD_PORT-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // random keys that land in one given bucket
  function automatic void collect_keys(int unsigned bucket, int count,
                                       ref logic [KEY_BITS-1:0] q [$]);
    logic [KEY_BITS-1:0] k;
    while (count > 0) begin
      k = $urandom;
      if (k > KEY_RESERVED && sb.set_index(k) == bucket) begin
        q.push_back(k);
        count--;
      end
    end
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_beat(logic cmd, logic [KEY_BITS-1:0] key,
                           logic [PAYLOAD_PORT-1:0] pay);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    key_i        <= key;
    payload_in_i <= pay;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [KEY_BITS-1:0]     fill_keys [$];
    logic [KEY_BITS-1:0]     hot_keys [$];
    logic [KEY_BITS-1:0]     known_keys [$];
    logic [KEY_BITS-1:0]     key;
    logic                    cmd;
    int unsigned             pick;

    in_valid_i   <= 1'b0;
    cmd_i        <= CMD_LOOKUP;
    key_i        <= '0;
    payload_in_i <= '0;
    calm = 1'b0;
    long_hold = 1'b0;

    collect_keys(sb.set_index(32'hFFFF_FFFF), 16, fill_keys);
    for (int s = 0; s < HOT_SETS; s++)
      collect_keys($urandom_range(0, BUCKETS - 1), HOT_PER_SET, hot_keys);

    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: reserved keys, key and payload extremes, present, miss, full bucket
    send_beat(CMD_LOOKUP, TAG_FREE, '0);
    send_beat(CMD_INSERT, KEY_RESERVED, '1);
    send_beat(CMD_INSERT, 32'hFFFF_FFFF, '1);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send_beat(CMD_INSERT, 32'hFFFF_FFFF, '0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, '1);
    send_beat(CMD_LOOKUP, 32'h0000_0002, '1);
    send_beat(CMD_INSERT, 32'h0000_0002, '0);
    send_beat(CMD_LOOKUP, 32'h0000_0002, '0);
    for (int i = 0; i < 16; i++) begin
      send_beat(CMD_INSERT, fill_keys[i], rand_payload());
      known_keys.push_back(fill_keys[i]);
    end
    send_beat(CMD_LOOKUP, fill_keys[14], '0);
    known_keys.push_back(32'hFFFF_FFFF);
    known_keys.push_back(32'h0000_0002);

    // result side stalls for a long stretch while beats keep coming
    long_hold = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n >= RANDOM_ITEMS - 200) calm = 1'b1;
      if (n == RANDOM_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      cmd  = CMD_LOOKUP;
      if (pick < 5) begin
        key = $urandom_range(0, 1);
        cmd = 1'($urandom_range(0, 1));
      end else if (pick < 30) begin
        key = $urandom;
        cmd = CMD_INSERT;
        known_keys.push_back(key);
      end else if (pick < 55) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 65) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        cmd = CMD_INSERT;
      end else if (pick < 75) begin
        key = $urandom;
      end else if (pick < 90) begin
        key = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
        cmd = CMD_INSERT;
        known_keys.push_back(key);
      end else begin
        key = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
      end
      send_beat(cmd, key, rand_payload());
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_hashed_set_assoc_decode_cache OK");
    end else begin
      $display("tb_hashed_set_assoc_decode_cache NOT OK");
    end
    $finish;
  end

endmodule
